>>> design/assert_macros.svh
// Assertion helpers. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/crast_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crast_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int W_BITS     = COORD_BITS + 2;
  localparam int CALC_BITS  = W_BITS + 2;

  localparam int OUTLINE_N = 8;
  localparam int FILL_N    = 4;
  localparam int IDX_W     = $clog2(OUTLINE_N);

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_t;

  typedef enum logic {
    MODE_OUTLINE = 1'b0,
    MODE_FILL    = 1'b1
  } mode_t;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [RAD_BITS-1:0]      rad_t;
  typedef logic signed [W_BITS-1:0] dec_t;
  typedef logic signed [W_BITS-1:0] pix_t;

  // Snapshot of one step: everything the result sequencer needs.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t ox;
    coord_t oy;
    mode_t  mode;
    logic   done;
  } grp_t;

  // Offsets and decision value after one step.
  typedef struct packed {
    coord_t ox;
    coord_t oy;
    dec_t   dec;
    logic   done;
  } next_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic take;
    logic busy;
  } emit_stat_t;

endpackage
`default_nettype wire

>>> design/crast_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface crast_in_if
  import crast_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t center_x;
  coord_t center_y;
  rad_t   radius;
  logic   fill_mode;

  modport source (output valid, req_type, center_x, center_y, radius, fill_mode,
                  input ready);
  modport sink (input valid, req_type, center_x, center_y, radius, fill_mode,
                output ready);
endinterface

interface crast_out_if
  import crast_pkg::*;
();
  logic valid;
  logic ready;
  pix_t x_start;
  pix_t x_end;
  pix_t row;
  logic last_of_step;
  logic done_res;

  modport source (output valid, x_start, x_end, row, last_of_step, done_res,
                  input ready);
  modport sink (input valid, x_start, x_end, row, last_of_step, done_res,
                output ready);
endinterface
`default_nettype wire

>>> design/crast_step.sv
`timescale 1ns / 1ps
`default_nettype none
module crast_step
  import crast_pkg::*;
(
  input  rad_t   rad,
  input  coord_t ox,
  input  coord_t oy,
  input  dec_t   dec,
  output next_t  nxt
);

  logic signed [CALC_BITS-1:0] d, oxe, oye, re, two_ox, nd, nx, ny;

  always_comb begin
    d      = CALC_BITS'(dec);
    oxe    = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, ox});
    oye    = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, oy});
    re     = $signed({{(CALC_BITS-RAD_BITS){1'b0}}, rad});
    two_ox = oxe <<< 1;
    nx     = oxe;
    ny     = oye;
    // Three update rules: move right, move down, or move diagonally.
    if (d >= two_ox) begin
      nd = d - two_ox - CALC_BITS'(1);
      nx = oxe + CALC_BITS'(1);
    end else if (d < ((re - oye) <<< 1)) begin
      nd = d + (oye <<< 1) - CALC_BITS'(1);
      ny = oye - CALC_BITS'(1);
    end else begin
      nd = d + ((oye - oxe - CALC_BITS'(1)) <<< 1);
      nx = oxe + CALC_BITS'(1);
      ny = oye - CALC_BITS'(1);
    end
    nxt.ox   = nx[COORD_BITS-1:0];
    nxt.oy   = ny[COORD_BITS-1:0];
    nxt.dec  = nd[W_BITS-1:0];
    nxt.done = (ny < nx);
  end

endmodule
`default_nettype wire

>>> design/crast_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module crast_emit
  import crast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        grp_load,
  input  grp_t        grp_in,
  output emit_stat_t  stat,
  crast_out_if.source out_ch
);

  localparam logic [IDX_W-1:0] OUT_LAST  = IDX_W'(OUTLINE_N - 1);
  localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(FILL_N - 1);

  grp_t             grp_r;
  logic             grp_valid_r;
  logic [IDX_W-1:0] k_r;
  logic             out_valid_r;
  pix_t             xs_r, xe_r, row_r;
  logic             last_r, done_r;

  pix_t xpo, xmo, xpy, xmy, ypo, ymo, ypx, ymx;
  pix_t xs, xe, rw;
  logic last, out_load;

  function automatic pix_t ext(input coord_t v);
    ext = $signed({{(W_BITS-COORD_BITS){1'b0}}, v});
  endfunction

  always_comb begin
    xpo = ext(grp_r.cx) + ext(grp_r.ox);
    xmo = ext(grp_r.cx) - ext(grp_r.ox);
    xpy = ext(grp_r.cx) + ext(grp_r.oy);
    xmy = ext(grp_r.cx) - ext(grp_r.oy);
    ypo = ext(grp_r.cy) + ext(grp_r.oy);
    ymo = ext(grp_r.cy) - ext(grp_r.oy);
    ypx = ext(grp_r.cy) + ext(grp_r.ox);
    ymx = ext(grp_r.cy) - ext(grp_r.ox);
    xs  = xmy;
    xe  = xpy;
    rw  = ymx;
    if (grp_r.mode == MODE_FILL) begin
      case (k_r)
        IDX_W'(0): begin xs = xmy; xe = xpy; rw = ypx; end
        IDX_W'(1): begin xs = xmo; xe = xpo; rw = ypo; end
        IDX_W'(2): begin xs = xmo; xe = xpo; rw = ymo; end
        default:   begin xs = xmy; xe = xpy; rw = ymx; end
      endcase
      last = (k_r == FILL_LAST);
    end else begin
      case (k_r)
        IDX_W'(0): begin xs = xpo; rw = ypo; end
        IDX_W'(1): begin xs = xpy; rw = ypx; end
        IDX_W'(2): begin xs = xmo; rw = ypo; end
        IDX_W'(3): begin xs = xmy; rw = ypx; end
        IDX_W'(4): begin xs = xpo; rw = ymo; end
        IDX_W'(5): begin xs = xpy; rw = ymx; end
        IDX_W'(6): begin xs = xmo; rw = ymo; end
        default:   begin xs = xmy; rw = ymx; end
      endcase
      xe   = xs;
      last = (k_r == OUT_LAST);
    end
  end

  assign out_load  = grp_valid_r && (!out_valid_r || out_ch.ready);
  assign stat.take = !grp_valid_r || (out_load && last);
  assign stat.busy = grp_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        k_r <= k_r + IDX_W'(1);
        if (last) begin
          grp_valid_r <= 1'b0;
        end
      end
      if (grp_load) begin
        grp_valid_r <= 1'b1;
        k_r         <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= grp_in;
    end
    if (out_load) begin
      xs_r   <= xs;
      xe_r   <= xe;
      row_r  <= rw;
      last_r <= last;
      done_r <= grp_r.done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.x_start      = xs_r;
  assign out_ch.x_end        = xe_r;
  assign out_ch.row          = row_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.done_res     = done_r;

endmodule
`default_nettype wire

>>> design/circle_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Circle rasterizer (Andres algorithm). A start transaction loads center, radius
// and mode, resets the offsets to (0, radius) and the decision value to radius-1,
// and produces nothing. Each step transaction produces one octant group, read
// from a snapshot of the current offsets: 8 points in outline mode or 4
// horizontal spans in fill mode, then advances the offsets. The step whose
// advance crosses the diagonal marks every result of its group with done_res and
// returns the block to idle; a step while idle is accepted and dropped. The
// single result register moves one result per cycle while the consumer holds
// ready high, and a group holds it until its last result has entered it. The
// next transaction is taken in the cycle the previous group's last result
// enters the result register, so the output never bubbles between groups
// while the consumer keeps ready high.
module circle_rasterizer
  import crast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  crast_in_if.sink    in_ch,
  crast_out_if.source out_ch
);

  // Circle state
  coord_t cx_r, cy_r, ox_r, oy_r;
  rad_t   rad_r;
  dec_t   dec_r;
  mode_t  mode_r;
  logic   active_r;

  next_t      step_nxt;
  emit_stat_t stat;
  grp_t       grp;
  logic       in_acc, is_step, grp_load;

  assign in_ch.ready = stat.take;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_step     = (req_t'(in_ch.req_type) == REQ_STEP);
  // Only a step on an active circle produces a group.
  assign grp_load    = in_acc && is_step && active_r;

  crast_step u_step (
    .rad (rad_r),
    .ox  (ox_r),
    .oy  (oy_r),
    .dec (dec_r),
    .nxt (step_nxt)
  );

  always_comb begin
    grp.cx   = cx_r;
    grp.cy   = cy_r;
    grp.ox   = ox_r;
    grp.oy   = oy_r;
    grp.mode = mode_r;
    grp.done = step_nxt.done;
  end

  crast_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp_load (grp_load),
    .grp_in   (grp),
    .stat     (stat),
    .out_ch   (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      rad_r    <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
      mode_r   <= MODE_OUTLINE;
      active_r <= 1'b0;
    end else if (in_acc && !is_step) begin
      // Start: load a new circle, abandoning any in progress.
      cx_r     <= in_ch.center_x;
      cy_r     <= in_ch.center_y;
      rad_r    <= in_ch.radius;
      mode_r   <= mode_t'(in_ch.fill_mode);
      ox_r     <= '0;
      oy_r     <= {{(COORD_BITS-RAD_BITS){1'b0}}, in_ch.radius};
      dec_r    <= $signed({{(W_BITS-RAD_BITS){1'b0}}, in_ch.radius}) - W_BITS'(1);
      active_r <= 1'b1;
    end else if (grp_load) begin
      // Step: advance the offsets once the group snapshot is captured.
      ox_r  <= step_nxt.ox;
      oy_r  <= step_nxt.oy;
      dec_r <= step_nxt.dec;
      if (step_nxt.done) begin
        active_r <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_step_loads_group, grp_load, stat.busy, "step on active circle lost its group")
  `ASSERT_NEXT(a_start_arms, in_acc && !is_step, active_r && (ox_r == '0), "start did not arm circle")
  `ASSERT_ALWAYS(a_span_order, !out_ch.valid || (out_ch.x_end >= out_ch.x_start), "span reversed")

endmodule
`default_nettype wire

>>> tb/crast_checker.sv
`timescale 1ns / 1ps
// Watches both channels, predicts the octant groups of each step and checks
// every result transaction in order.
module crast_checker
  import crast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  crast_in_if         in_mon,
  crast_out_if        out_mon,
  output int unsigned errors,
  output int unsigned outstanding
);

  typedef struct packed {
    pix_t x_start;
    pix_t x_end;
    pix_t row;
    logic last_of_step;
    logic done_res;
  } span_t;

  span_t       span_q[$];
  coord_t      ctr_x;
  coord_t      ctr_y;
  rad_t        rad;
  coord_t      off_x;
  coord_t      off_y;
  dec_t        decision;
  mode_t       mode;
  logic        active;
  int unsigned bad = 0;

  function automatic void add_span(int xs, int xe, int rw, logic last, logic fin);
    span_t s;
    s.x_start      = pix_t'(xs);
    s.x_end        = pix_t'(xe);
    s.row          = pix_t'(rw);
    s.last_of_step = last;
    s.done_res     = fin;
    span_q.push_back(s);
  endfunction

  function automatic void load_circle(coord_t col, coord_t rw, rad_t r, mode_t m);
    ctr_x    = col;
    ctr_y    = rw;
    rad      = r;
    mode     = m;
    off_x    = '0;
    off_y    = coord_t'(r);
    decision = dec_t'(int'(r) - 1);
    active   = 1'b1;
  endfunction

  // Emit the group for the current offsets, then advance by the Andres rules.
  function automatic void step_circle();
    int   x, y, ox, oy, r, d, nx, ny, nd;
    logic fin;
    if (!active) return;
    x  = int'(ctr_x);
    y  = int'(ctr_y);
    r  = int'(rad);
    ox = int'(off_x);
    oy = int'(off_y);
    d  = int'(decision);
    nx = ox;
    ny = oy;
    if (d >= 2 * ox) begin
      nd = d - (2 * ox + 1);
      nx = ox + 1;
    end else if (d < 2 * (r - oy)) begin
      nd = d + 2 * oy - 1;
      ny = oy - 1;
    end else begin
      nd = d + 2 * (oy - ox - 1);
      ny = oy - 1;
      nx = ox + 1;
    end
    fin = (ny < nx);
    if (mode == MODE_OUTLINE) begin
      add_span(x + ox, x + ox, y + oy, 1'b0, fin);
      add_span(x + oy, x + oy, y + ox, 1'b0, fin);
      add_span(x - ox, x - ox, y + oy, 1'b0, fin);
      add_span(x - oy, x - oy, y + ox, 1'b0, fin);
      add_span(x + ox, x + ox, y - oy, 1'b0, fin);
      add_span(x + oy, x + oy, y - ox, 1'b0, fin);
      add_span(x - ox, x - ox, y - oy, 1'b0, fin);
      add_span(x - oy, x - oy, y - ox, 1'b1, fin);
    end else begin
      add_span(x - oy, x + oy, y + ox, 1'b0, fin);
      add_span(x - ox, x + ox, y + oy, 1'b0, fin);
      add_span(x - ox, x + ox, y - oy, 1'b0, fin);
      add_span(x - oy, x + oy, y - ox, 1'b1, fin);
    end
    off_x    = coord_t'(nx);
    off_y    = coord_t'(ny);
    decision = dec_t'(nd);
    if (fin) active = 1'b0;
  endfunction

  function automatic void flag(string what, span_t want, span_t got);
    bad++;
    if (bad <= 10)
      $display("%0t: %s: exp x_start=%0d x_end=%0d row=%0d last=%0b done=%0b",
               $realtime, what, want.x_start, want.x_end, want.row,
               want.last_of_step, want.done_res,
               " | got x_start=%0d x_end=%0d row=%0d last=%0b done=%0b",
               got.x_start, got.x_end, got.row, got.last_of_step, got.done_res);
  endfunction

  function automatic void check_result();
    span_t want;
    span_t got;
    string diff;
    got.x_start      = out_mon.x_start;
    got.x_end        = out_mon.x_end;
    got.row          = out_mon.row;
    got.last_of_step = out_mon.last_of_step;
    got.done_res     = out_mon.done_res;
    if (span_q.size() == 0) begin
      flag("result with nothing pending", '0, got);
      return;
    end
    want = span_q.pop_front();
    diff = "";
    if (got.x_start !== want.x_start) diff = {diff, " x_start"};
    if (got.x_end !== want.x_end) diff = {diff, " x_end"};
    if (got.row !== want.row) diff = {diff, " row"};
    if (got.last_of_step !== want.last_of_step) diff = {diff, " last_of_step"};
    if (got.done_res !== want.done_res) diff = {diff, " done_res"};
    if (diff != "") flag({"wrong", diff}, want, got);
  endfunction

  // Take the input transaction before the output one: a result accepted at
  // the same edge always belongs to an earlier step.
  always @(posedge clk) begin
    if (!rst_n) begin
      span_q.delete();
      ctr_x    = '0;
      ctr_y    = '0;
      rad      = '0;
      off_x    = '0;
      off_y    = '0;
      decision = '0;
      mode     = MODE_OUTLINE;
      active   = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (req_t'(in_mon.req_type) == REQ_START)
          load_circle(in_mon.center_x, in_mon.center_y, in_mon.radius,
                      mode_t'(in_mon.fill_mode));
        else
          step_circle();
      end
      if (out_mon.valid && out_mon.ready) check_result();
    end
    errors      <= bad;
    outstanding <= span_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the circle rasterizer bench. This module only makes traffic and
// gives the verdict; prediction and comparison live in crast_checker.
module tb;
  import crast_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned spans_owed;
  // When set, neither side idles: used for whole circles at a time so that
  // back-to-back groups get exercised.
  bit          no_idle;

  crast_in_if  in_ch();
  crast_out_if out_ch();

  circle_rasterizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  crast_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (mismatch_count),
    .outstanding (spans_owed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold off, raise valid with the payload, and wait for the transaction.
  // Valid is only lowered when a gap is drawn, so it never drops and rises in
  // the same step.
  task automatic send_item(input req_t kind, input coord_t col, input coord_t rw,
                           input rad_t r, input mode_t fm);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.center_x  <= col;
    in_ch.center_y  <= rw;
    in_ch.radius    <= r;
    in_ch.fill_mode <= fm;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Steps ignore the payload, so fill it with noise to toggle every bit.
  task automatic send_step();
    send_item(REQ_STEP, coord_t'($urandom), coord_t'($urandom), rad_t'($urandom),
              mode_t'($urandom_range(0, 1)));
  endtask

  // Bias toward the edges of the coordinate range.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Result side: draw a stall per result, then hold ready until a transaction.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int          sent;
    int          rlen;
    int          steps;
    int unsigned sel;
    no_idle            = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_START;
    in_ch.center_x    <= '0;
    in_ch.center_y    <= '0;
    in_ch.radius      <= '0;
    in_ch.fill_mode   <= MODE_OUTLINE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Step with no circle loaded: must be dropped.
    send_step();
    // Small outline circle at the origin: negative columns and rows, three
    // steps to finish, then one stray step after the done group.
    send_item(REQ_START, '0, '0, rad_t'(3), MODE_OUTLINE);
    repeat (4) send_step();
    // Zero radius, fill, at the far corner: one group of single-pixel spans.
    send_item(REQ_START, '1, '1, '0, MODE_FILL);
    send_step();
    // Zero radius, outline: the center point eight times.
    send_item(REQ_START, coord_t'(2730), coord_t'(1365), '0, MODE_OUTLINE);
    send_step();
    // Largest radius, outline, then abandon it with a new start.
    send_item(REQ_START, '1, '0, '1, MODE_OUTLINE);
    repeat (2) send_step();
    send_item(REQ_START, '0, '1, '1, MODE_FILL);
    repeat (2) send_step();
    // Radius one, fill: exercises the second update rule.
    send_item(REQ_START, coord_t'(2048), coord_t'(1365), rad_t'(1), MODE_FILL);
    repeat (2) send_step();

    // Random part: mostly whole circles of small radius, some cut short or
    // abandoned, with stray steps mixed in. Together with the directed part
    // above this comes to about 130 transactions.
    sent = 0;
    while (sent < 110) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_step();
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7)      rlen = $urandom_range(0, 12);
        else if (sel < 9) rlen = $urandom_range(13, 60);
        else              rlen = $urandom_range(61, 2047);
        // About r/sqrt(2) steps close an octant; sometimes run one over.
        steps = (rlen * 724) / 1024 + 1 + $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, steps);
        if (rlen > 60 && steps > 20) steps = 20;
        send_item(REQ_START, pick_coord(), pick_coord(), rad_t'(rlen),
                  mode_t'($urandom_range(0, 1)));
        sent++;
        repeat (steps) begin
          send_step();
          sent++;
        end
      end
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then give the block time to show any extra result.
    do @(posedge clk); while (spans_owed != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && spans_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
